/* hdl/avr_pkg.sv */
// Package for the axis vector rotator: default widths, axis codes, side-band type
// and the CORDIC micro-rotation angle table. Used by every file in hdl/.
`default_nettype none

package avr_pkg;

  localparam int COORD_WIDTH_DEF   = 32;
  localparam int ANGLE_WIDTH_DEF   = 32;
  localparam int CORDIC_STAGES_DEF = 24;
  localparam int GUARD_BITS        = 8;
  localparam int DW_EXTRA          = 3;
  localparam int ZW                = 64;

  localparam logic [63:0] PI_Q61         = 64'h6487ED5110B4611A;
  localparam logic [63:0] QUARTER_PI_Q61 = 64'h1921FB54442D1847;
  localparam logic [31:0] KINV_Q32       = 32'd2608131496;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef struct packed {
    logic  vld;
    axis_t axis;
  } avr_side_t;

  // Shift-subtract quotient, evaluated only while building constants.
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], num[k]};
      if (r >= den) begin
        r = r - den;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // Arctangent of 2^-i in Q2.61 from the truncated series, rounded half up.
  function automatic logic [63:0] stage_angle(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    int k;
    int sh;
    sum = '0;
    if (i == 0) begin
      return QUARTER_PI_Q61;
    end
    for (k = 0; i * (2 * k + 1) <= 63; k++) begin
      sh = 63 - i * (2 * k + 1);
      term = div_u64(64'd1 << sh, 64'(2 * k + 1));
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return (sum + 64'd2) >> 2;
  endfunction

endpackage

`default_nettype wire

/* hdl/avr_if.sv */
// Valid/ready channel interfaces for the axis vector rotator input and result words.
// Depends on avr_pkg for the default widths.
`default_nettype none

interface avr_in_if import avr_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    axis_select;
  logic signed [ANGLE_WIDTH-1:0] rotate_angle;
  logic signed [COORD_WIDTH-1:0] in_x;
  logic signed [COORD_WIDTH-1:0] in_y;
  logic signed [COORD_WIDTH-1:0] in_z;

  modport source (output valid, axis_select, rotate_angle, in_x, in_y, in_z, input ready);
  modport sink (input valid, axis_select, rotate_angle, in_x, in_y, in_z, output ready);
endinterface

interface avr_out_if import avr_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic                          saturated;

  modport source (output valid, out_x, out_y, out_z, saturated, input ready);
  modport sink (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

`default_nettype wire

/* hdl/axis_vector_rotate.sv */
// Rotates a Q16.16 vector about the x, y or z axis by a Q4.27 angle in radians.
// Pipeline: six fold stages, one per CORDIC micro-rotation and six gain stages, then the
// output register.
// Throughput: one word per cycle while the second output entry is empty; every stage advances
// together, a stalled consumer sends the last finished word there, and in ready is low while it is full.
// Reset (synchronous, active low) clears all valid bits; datapath registers keep their values.
`default_nettype none

module axis_vector_rotate import avr_pkg::*; #(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  avr_in_if.sink    in_s,
  avr_out_if.source out_s
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + GUARD_BITS + DW_EXTRA;

  logic                 en;
  avr_side_t            fold_side;
  logic signed [DW-1:0] fold_a;
  logic signed [DW-1:0] fold_b;
  logic signed [ZW-1:0] fold_z;
  logic [3*CW-1:0]      fold_pass;
  avr_side_t            rot_side;
  logic signed [DW-1:0] rot_a;
  logic signed [DW-1:0] rot_b;
  logic [3*CW-1:0]      rot_pass;
  logic                 fin_vld;
  logic signed [CW-1:0] fin_x;
  logic signed [CW-1:0] fin_y;
  logic signed [CW-1:0] fin_z;
  logic                 fin_sat;

  logic                 out_vld_r;
  logic                 out_vld_nxt;
  logic signed [CW-1:0] out_x_r;
  logic signed [CW-1:0] out_y_r;
  logic signed [CW-1:0] out_z_r;
  logic                 out_sat_r;
  logic                 skid_vld_r;
  logic                 skid_vld_nxt;
  logic signed [CW-1:0] skid_x_r;
  logic signed [CW-1:0] skid_y_r;
  logic signed [CW-1:0] skid_z_r;
  logic                 skid_sat_r;
  logic                 take;
  logic                 push;
  logic                 ld_out_fin;
  logic                 ld_out_skid;
  logic                 ld_skid;

  assign en         = !skid_vld_r;
  assign in_s.ready = en;

  avr_fold #(
    .COORD_WIDTH (COORD_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_fold (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_s.valid),
    .axis_select  (in_s.axis_select),
    .rotate_angle (in_s.rotate_angle),
    .in_x         (in_s.in_x),
    .in_y         (in_s.in_y),
    .in_z         (in_s.in_z),
    .side_o       (fold_side),
    .a_o          (fold_a),
    .b_o          (fold_b),
    .z_o          (fold_z),
    .pass_o       (fold_pass)
  );

  avr_cordic #(
    .COORD_WIDTH   (COORD_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .side_i (fold_side),
    .a_i    (fold_a),
    .b_i    (fold_b),
    .z_i    (fold_z),
    .pass_i (fold_pass),
    .side_o (rot_side),
    .a_o    (rot_a),
    .b_o    (rot_b),
    .pass_o (rot_pass)
  );

  avr_gain #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_gain (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .side_i (rot_side),
    .a_i    (rot_a),
    .b_i    (rot_b),
    .pass_i (rot_pass),
    .vld_o  (fin_vld),
    .x_o    (fin_x),
    .y_o    (fin_y),
    .z_o    (fin_z),
    .sat_o  (fin_sat)
  );

  always_comb begin
    take         = out_vld_r && out_s.ready;
    push         = en && fin_vld;
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    ld_out_fin   = 1'b0;
    ld_out_skid  = 1'b0;
    ld_skid      = 1'b0;
    if (skid_vld_r) begin
      if (take) begin
        ld_out_skid  = 1'b1;
        skid_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_vld_r || take) begin
        ld_out_fin  = 1'b1;
        out_vld_nxt = 1'b1;
      end else begin
        ld_skid      = 1'b1;
        skid_vld_nxt = 1'b1;
      end
    end else if (take) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out_fin) begin
      out_x_r   <= fin_x;
      out_y_r   <= fin_y;
      out_z_r   <= fin_z;
      out_sat_r <= fin_sat;
    end else if (ld_out_skid) begin
      out_x_r   <= skid_x_r;
      out_y_r   <= skid_y_r;
      out_z_r   <= skid_z_r;
      out_sat_r <= skid_sat_r;
    end
    if (ld_skid) begin
      skid_x_r   <= fin_x;
      skid_y_r   <= fin_y;
      skid_z_r   <= fin_z;
      skid_sat_r <= fin_sat;
    end
  end

  assign out_s.valid     = out_vld_r;
  assign out_s.out_x     = out_x_r;
  assign out_s.out_y     = out_y_r;
  assign out_s.out_z     = out_z_r;
  assign out_s.saturated = out_sat_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("Skid buffer holds a word while the output register is empty.");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && !out_s.ready && fin_vld))
    else $error("Skid buffer filled without a stalled output and a finished word.");

  a_stall_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
    fin_vld && !en |=> fin_vld)
    else $error("Last pipeline stage lost its word during a stall.");

endmodule

`default_nettype wire

/* hdl/avr_fold.sv */
// Front end: picks the rotated coordinate pair, folds the angle into [-pi/2, pi/2]
// over six register stages and forms the Q2.61 residual angle. Depends on avr_pkg.
`default_nettype none

module avr_fold import avr_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [1:0]                             axis_select,
  input  logic signed [ANGLE_WIDTH-1:0]          rotate_angle,
  input  logic signed [COORD_WIDTH-1:0]          in_x,
  input  logic signed [COORD_WIDTH-1:0]          in_y,
  input  logic signed [COORD_WIDTH-1:0]          in_z,
  output avr_side_t                              side_o,
  output logic signed [COORD_WIDTH+GUARD_BITS+DW_EXTRA-1:0] a_o,
  output logic signed [COORD_WIDTH+GUARD_BITS+DW_EXTRA-1:0] b_o,
  output logic signed [ZW-1:0]                   z_o,
  output logic [3*COORD_WIDTH-1:0]               pass_o
);

  localparam int DW = COORD_WIDTH + GUARD_BITS + DW_EXTRA;
  localparam int FW = ANGLE_WIDTH + 1;
  localparam int S  = 66 - ANGLE_WIDTH;
  localparam int NSTG = 6;

  localparam logic [64:0] PI_W      = ({1'b0, PI_Q61} + (65'd1 << (S - 1))) >> S;
  localparam logic [64:0] TWO_PI_W  = ({1'b0, PI_Q61} + (65'd1 << (S - 2))) >> (S - 1);
  localparam logic [64:0] HALF_PI_W = ({1'b0, PI_Q61} + (65'd1 << S)) >> (S + 1);

  localparam logic signed [FW-1:0] PI_A       = $signed(FW'(PI_W));
  localparam logic signed [FW-1:0] TWO_PI_A   = $signed(FW'(TWO_PI_W));
  localparam logic signed [FW-1:0] HALF_PI_A  = $signed(FW'(HALF_PI_W));
  localparam logic signed [FW-1:0] NEG_PI_A   = -PI_A;
  localparam logic signed [FW-1:0] NEG_HALF_A = -HALF_PI_A;

  avr_side_t                 side_r [0:NSTG-1];
  logic [3*COORD_WIDTH-1:0]  pass_r [0:NSTG-1];
  logic signed [DW-1:0]      a_r    [0:NSTG-1];
  logic signed [DW-1:0]      b_r    [0:NSTG-1];
  logic signed [FW-1:0]      th_r   [0:4];
  logic signed [ZW-1:0]      z_r;

  logic signed [COORD_WIDTH-1:0] sel_a;
  logic signed [COORD_WIDTH-1:0] sel_b;
  logic signed [DW-1:0]          a_ext;
  logic signed [DW-1:0]          b_ext;
  logic signed [FW-1:0]          th_half_nxt;
  logic signed [DW-1:0]          a_half_nxt;
  logic signed [DW-1:0]          b_half_nxt;
  logic signed [ZW-1:0]          th_wide;
  logic signed [ZW-1:0]          z_nxt;

  always_comb begin
    unique case (axis_t'(axis_select))
      AXIS_X: begin
        sel_a = in_y;
        sel_b = in_z;
      end
      AXIS_Y: begin
        sel_a = in_x;
        sel_b = in_z;
      end
      AXIS_Z, AXIS_NONE: begin
        sel_a = in_x;
        sel_b = in_y;
      end
      default: begin
        sel_a = in_x;
        sel_b = in_y;
      end
    endcase
    a_ext = DW'(sel_a) <<< GUARD_BITS;
    b_ext = DW'(sel_b) <<< GUARD_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r[0] <= '0;
    end else if (en) begin
      side_r[0] <= '{vld: in_valid, axis: axis_t'(axis_select)};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pass_r[0] <= {in_z, in_y, in_x};
      a_r[0]    <= a_ext;
      b_r[0]    <= b_ext;
      th_r[0]   <= FW'(rotate_angle);
    end
  end

  for (genvar j = 1; j <= 3; j++) begin : g_wrap
    logic signed [FW-1:0] th_nxt;

    always_comb begin
      if (th_r[j-1] > PI_A) begin
        th_nxt = th_r[j-1] - TWO_PI_A;
      end else if (th_r[j-1] < NEG_PI_A) begin
        th_nxt = th_r[j-1] + TWO_PI_A;
      end else begin
        th_nxt = th_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[j] <= '0;
      end else if (en) begin
        side_r[j] <= side_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pass_r[j] <= pass_r[j-1];
        a_r[j]    <= a_r[j-1];
        b_r[j]    <= b_r[j-1];
        th_r[j]   <= th_nxt;
      end
    end
  end

  // A half turn brings the angle into the CORDIC convergence range.
  always_comb begin
    th_half_nxt = th_r[3];
    a_half_nxt  = a_r[3];
    b_half_nxt  = b_r[3];
    if (th_r[3] > HALF_PI_A) begin
      th_half_nxt = th_r[3] - PI_A;
      a_half_nxt  = -a_r[3];
      b_half_nxt  = -b_r[3];
    end else if (th_r[3] < NEG_HALF_A) begin
      th_half_nxt = th_r[3] + PI_A;
      a_half_nxt  = -a_r[3];
      b_half_nxt  = -b_r[3];
    end
  end

  always_comb begin
    th_wide = ZW'(th_r[4]);
    z_nxt   = -(th_wide <<< S);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r[4] <= '0;
      side_r[5] <= '0;
    end else if (en) begin
      side_r[4] <= side_r[3];
      side_r[5] <= side_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pass_r[4] <= pass_r[3];
      a_r[4]    <= a_half_nxt;
      b_r[4]    <= b_half_nxt;
      th_r[4]   <= th_half_nxt;
      pass_r[5] <= pass_r[4];
      a_r[5]    <= a_r[4];
      b_r[5]    <= b_r[4];
      z_r       <= z_nxt;
    end
  end

  assign side_o = side_r[NSTG-1];
  assign pass_o = pass_r[NSTG-1];
  assign a_o    = a_r[NSTG-1];
  assign b_o    = b_r[NSTG-1];
  assign z_o    = z_r;

endmodule

`default_nettype wire

/* hdl/avr_cordic.sv */
// Unrolled rotation-mode CORDIC, one micro-rotation per register stage.
// Depends on avr_pkg for the angle table function and the side-band type.
`default_nettype none

module avr_cordic import avr_pkg::*; #(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  avr_side_t                              side_i,
  input  logic signed [COORD_WIDTH+GUARD_BITS+DW_EXTRA-1:0] a_i,
  input  logic signed [COORD_WIDTH+GUARD_BITS+DW_EXTRA-1:0] b_i,
  input  logic signed [ZW-1:0]                   z_i,
  input  logic [3*COORD_WIDTH-1:0]               pass_i,
  output avr_side_t                              side_o,
  output logic signed [COORD_WIDTH+GUARD_BITS+DW_EXTRA-1:0] a_o,
  output logic signed [COORD_WIDTH+GUARD_BITS+DW_EXTRA-1:0] b_o,
  output logic [3*COORD_WIDTH-1:0]               pass_o
);

  localparam int DW = COORD_WIDTH + GUARD_BITS + DW_EXTRA;
  localparam int N  = CORDIC_STAGES;

  avr_side_t                side_r [0:N-1];
  logic [3*COORD_WIDTH-1:0] pass_r [0:N-1];
  logic signed [DW-1:0]     a_r    [0:N-1];
  logic signed [DW-1:0]     b_r    [0:N-1];
  logic signed [ZW-1:0]     z_r    [0:N-1];

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [ZW-1:0] T = $signed(stage_angle(i));

    avr_side_t                side_p;
    logic [3*COORD_WIDTH-1:0] pass_p;
    logic signed [DW-1:0]     a_p;
    logic signed [DW-1:0]     b_p;
    logic signed [ZW-1:0]     z_p;
    logic signed [DW-1:0]     a_nxt;
    logic signed [DW-1:0]     b_nxt;
    logic signed [ZW-1:0]     z_nxt;

    if (i == 0) begin : g_head
      assign side_p = side_i;
      assign pass_p = pass_i;
      assign a_p    = a_i;
      assign b_p    = b_i;
      assign z_p    = z_i;
    end else begin : g_body
      assign side_p = side_r[i-1];
      assign pass_p = pass_r[i-1];
      assign a_p    = a_r[i-1];
      assign b_p    = b_r[i-1];
      assign z_p    = z_r[i-1];
    end

    always_comb begin
      if (!z_p[ZW-1]) begin
        a_nxt = a_p - (b_p >>> i);
        b_nxt = b_p + (a_p >>> i);
        z_nxt = z_p - T;
      end else begin
        a_nxt = a_p + (b_p >>> i);
        b_nxt = b_p - (a_p >>> i);
        z_nxt = z_p + T;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[i] <= '0;
      end else if (en) begin
        side_r[i] <= side_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pass_r[i] <= pass_p;
        a_r[i]    <= a_nxt;
        b_r[i]    <= b_nxt;
        z_r[i]    <= z_nxt;
      end
    end
  end

  assign side_o = side_r[N-1];
  assign pass_o = pass_r[N-1];
  assign a_o    = a_r[N-1];
  assign b_o    = b_r[N-1];

endmodule

`default_nettype wire

/* hdl/avr_gain.sv */
// Gain correction, rounding and saturation of the rotated pair, then reassembly of
// the x, y, z result over six register stages. Depends on avr_pkg.
`default_nettype none

module avr_gain import avr_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  avr_side_t                              side_i,
  input  logic signed [COORD_WIDTH+GUARD_BITS+DW_EXTRA-1:0] a_i,
  input  logic signed [COORD_WIDTH+GUARD_BITS+DW_EXTRA-1:0] b_i,
  input  logic [3*COORD_WIDTH-1:0]               pass_i,
  output logic                                   vld_o,
  output logic signed [COORD_WIDTH-1:0]          x_o,
  output logic signed [COORD_WIDTH-1:0]          y_o,
  output logic signed [COORD_WIDTH-1:0]          z_o,
  output logic                                   sat_o
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + GUARD_BITS + DW_EXTRA;
  localparam int MAGW = (DW > 32) ? DW : 33;
  localparam int HW   = MAGW - 32;
  localparam int RW   = HW + 33;
  localparam int RSW  = RW - GUARD_BITS;

  localparam logic [RSW-1:0] POS_LIM = (RSW'(1) << (CW - 1)) - RSW'(1);
  localparam logic [RSW-1:0] NEG_LIM = RSW'(1) << (CW - 1);
  localparam logic [CW-1:0]  CMAX    = {1'b0, {(CW - 1){1'b1}}};
  localparam logic [CW-1:0]  CMIN    = {1'b1, {(CW - 1){1'b0}}};
  localparam logic [RW-1:0]  HALF_LSB = RW'(1) << (GUARD_BITS - 1);

  avr_side_t       side_r [1:5];
  logic [3*CW-1:0] pass_r [1:5];
  logic [CW-1:0]   res    [0:1];
  logic            clip   [0:1];

  logic            vld_r;
  logic [CW-1:0]   x_r;
  logic [CW-1:0]   y_r;
  logic [CW-1:0]   z_r;
  logic            sat_r;
  logic [CW-1:0]   x_nxt;
  logic [CW-1:0]   y_nxt;
  logic [CW-1:0]   z_nxt;
  logic            sat_nxt;
  logic [CW-1:0]   px;
  logic [CW-1:0]   py;
  logic [CW-1:0]   pz;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [DW-1:0] v_in;
    logic signed [MAGW:0] v_ext;
    logic [MAGW-1:0]      mag_nxt;
    logic [63:0]          plo_nxt;
    logic [HW+31:0]       phi_nxt;
    logic [63:0]          lo_round;
    logic [RW-1:0]        rsum;
    logic                 sgn_r [1:5];
    logic [MAGW-1:0]      mag_r;
    logic [63:0]          plo_r;
    logic [HW-1:0]        hi_r;
    logic [HW+31:0]       phi_r;
    logic [31:0]          lop_r;
    logic [RW-1:0]        r_r;
    logic [RSW-1:0]       rs_r;

    if (l == 0) begin : g_a
      assign v_in = a_i;
    end else begin : g_b
      assign v_in = b_i;
    end

    always_comb begin
      v_ext    = (MAGW + 1)'(v_in);
      mag_nxt  = MAGW'(v_in[DW-1] ? -v_ext : v_ext);
      plo_nxt  = mag_r[31:0] * KINV_Q32;
      phi_nxt  = hi_r * KINV_Q32;
      lo_round = plo_r + 64'h0000_0000_8000_0000;
      rsum     = r_r + HALF_LSB;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sgn_r[1] <= v_in[DW-1];
        mag_r    <= mag_nxt;
        sgn_r[2] <= sgn_r[1];
        plo_r    <= plo_nxt;
        hi_r     <= mag_r[MAGW-1:32];
        sgn_r[3] <= sgn_r[2];
        phi_r    <= phi_nxt;
        lop_r    <= lo_round[63:32];
        sgn_r[4] <= sgn_r[3];
        r_r      <= RW'(phi_r) + RW'(lop_r);
        sgn_r[5] <= sgn_r[4];
        rs_r     <= rsum[RW-1:GUARD_BITS];
      end
    end

    always_comb begin
      if (sgn_r[5]) begin
        clip[l] = rs_r > NEG_LIM;
        res[l]  = clip[l] ? CMIN : -(rs_r[CW-1:0]);
      end else begin
        clip[l] = rs_r > POS_LIM;
        res[l]  = clip[l] ? CMAX : rs_r[CW-1:0];
      end
    end
  end

  for (genvar k = 1; k <= 5; k++) begin : g_side
    avr_side_t       side_p;
    logic [3*CW-1:0] pass_p;

    if (k == 1) begin : g_head
      assign side_p = side_i;
      assign pass_p = pass_i;
    end else begin : g_body
      assign side_p = side_r[k-1];
      assign pass_p = pass_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k] <= '0;
      end else if (en) begin
        side_r[k] <= side_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pass_r[k] <= pass_p;
      end
    end
  end

  always_comb begin
    px = pass_r[5][CW-1:0];
    py = pass_r[5][2*CW-1:CW];
    pz = pass_r[5][3*CW-1:2*CW];
    sat_nxt = clip[0] | clip[1];
    unique case (side_r[5].axis)
      AXIS_X: begin
        x_nxt = px;
        y_nxt = res[0];
        z_nxt = res[1];
      end
      AXIS_Y: begin
        x_nxt = res[0];
        y_nxt = py;
        z_nxt = res[1];
      end
      AXIS_Z: begin
        x_nxt = res[0];
        y_nxt = res[1];
        z_nxt = pz;
      end
      AXIS_NONE: begin
        x_nxt = px;
        y_nxt = py;
        z_nxt = pz;
        sat_nxt = 1'b0;
      end
      default: begin
        x_nxt = px;
        y_nxt = py;
        z_nxt = pz;
        sat_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= side_r[5].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;
  assign sat_o = sat_r;

endmodule

`default_nettype wire
